FILE: src/mexp_pkg.sv
// Shared definitions for the modular exponentiation block.
// Holds the default data width, the product operation codes and the
// command/status structs between controller and datapath. No dependencies.
package mexp_pkg;

	localparam int DATA_WIDTH_DEF = 64;

	localparam logic [1:0] OP_REDUCE = 2'd0;
	localparam logic [1:0] OP_MUL    = 2'd1;
	localparam logic [1:0] OP_SQR    = 2'd2;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [1:0] op;
		logic       step;
		logic       write;
		logic       shift;
		logic       finish;
	} mexp_cmd_t;

	typedef struct packed {
		logic mod_zero;
		logic expo_zero;
		logic expo_bit0;
		logic expo_rest_zero;
		logic py_zero;
	} mexp_status_t;

endpackage

FILE: src/mexp_in_if.sv
// Input channel: base, exponent and modulus with valid/ready.
// Depends on mexp_pkg for the default width.
interface mexp_in_if import mexp_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
);
	logic         valid;
	logic         ready;
	logic [W-1:0] base_value;
	logic [W-1:0] exponent_value;
	logic [W-1:0] modulus_value;

	modport source (output valid, output base_value, output exponent_value,
		output modulus_value, input ready);
	modport sink (input valid, input base_value, input exponent_value,
		input modulus_value, output ready);
endinterface

FILE: src/mexp_out_if.sv
// Output channel: power result and bad-modulus flag with valid/ready.
// Depends on mexp_pkg for the default width.
interface mexp_out_if import mexp_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
);
	logic         valid;
	logic         ready;
	logic [W-1:0] power_result;
	logic         bad_modulus;

	modport source (output valid, output power_result, output bad_modulus, input ready);
	modport sink (input valid, input power_result, input bad_modulus, output ready);
endinterface

FILE: src/mexp_datapath.sv
// Datapath: operand registers, bit-serial shift-and-add modular product
// engine and result registers. Depends on mexp_pkg.
module mexp_datapath import mexp_pkg::*; #(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic [W-1:0] base_in,
	input  logic [W-1:0] expo_in,
	input  logic [W-1:0] mod_in,
	input  mexp_cmd_t    cmd,
	output mexp_status_t status,
	output logic [W-1:0] power_result,
	output logic         bad_modulus
);

	logic [W-1:0] base_q, expo_q, mod_q, acc_q;
	logic [W-1:0] pacc_q, pdbl_q, py_q;
	logic [W-1:0] res_q;
	logic         bad_q;

	logic [W:0]   mod_x, sum_a, sum_d;
	logic [W-1:0] red_a, red_d, one, start_dbl;
	logic         mod_one;

	assign one     = {{(W-1){1'b0}}, 1'b1};
	assign mod_one = (mod_q == one);
	assign mod_x   = {1'b0, mod_q};

	always_comb begin
		sum_a = {1'b0, pacc_q} + {1'b0, pdbl_q};
		sum_d = {pdbl_q, 1'b0};
		red_a = (sum_a >= mod_x) ? W'(sum_a - mod_x) : sum_a[W-1:0];
		red_d = (sum_d >= mod_x) ? W'(sum_d - mod_x) : sum_d[W-1:0];
	end

	always_comb begin
		unique case (cmd.op)
			OP_REDUCE: start_dbl = mod_one ? '0 : one;
			OP_MUL:    start_dbl = mod_one ? '0 : acc_q;
			default:   start_dbl = base_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_in;
			expo_q <= expo_in;
			mod_q  <= mod_in;
			acc_q  <= one;
		end else begin
			if (cmd.write) begin
				if (cmd.op == OP_MUL) begin
					acc_q <= pacc_q;
				end else begin
					base_q <= pacc_q;
				end
			end
			if (cmd.shift) begin
				expo_q <= expo_q >> 1;
			end
		end

		if (cmd.start) begin
			pacc_q <= '0;
			pdbl_q <= start_dbl;
			py_q   <= base_q;
		end else if (cmd.step) begin
			if (py_q[0]) begin
				pacc_q <= red_a;
			end
			pdbl_q <= red_d;
			py_q   <= py_q >> 1;
		end

		if (cmd.finish) begin
			res_q <= status.mod_zero ? '0 : acc_q;
			bad_q <= status.mod_zero;
		end
	end

	assign status.mod_zero       = (mod_q == '0);
	assign status.expo_zero      = (expo_q == '0);
	assign status.expo_bit0      = expo_q[0];
	assign status.expo_rest_zero = (expo_q[W-1:1] == '0);
	assign status.py_zero        = (py_q == '0);

	assign power_result = res_q;
	assign bad_modulus  = bad_q;

endmodule

FILE: src/mexp_ctrl.sv
// Controller: sequences base reduction, multiplies and squarings over the
// exponent bits, and owns both handshakes. Depends on mexp_pkg.
module mexp_ctrl import mexp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  mexp_status_t status,
	output mexp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_NEXT  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q, op_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		op_d     = op_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (status.mod_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = OP_REDUCE;
					op_d      = OP_REDUCE;
					state_d   = S_RUN;
				end
			end
			S_RUN: begin
				if (status.py_zero) begin
					cmd.write = 1'b1;
					cmd.op    = op_q;
					cmd.shift = (op_q == OP_SQR);
					state_d   = S_NEXT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_NEXT: begin
				priority if (op_q == OP_MUL && status.expo_rest_zero) begin
					state_d = S_FIN;
				end else if (op_q == OP_MUL) begin
					cmd.start = 1'b1;
					cmd.op    = OP_SQR;
					op_d      = OP_SQR;
					state_d   = S_RUN;
				end else if (status.expo_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = status.expo_bit0 ? OP_MUL : OP_SQR;
					op_d      = status.expo_bit0 ? OP_MUL : OP_SQR;
					state_d   = S_RUN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_REDUCE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/modular_exponentiation.sv
// Modular exponentiation: power_result = base_value ^ exponent_value mod modulus_value.
// in_ch carries base, exponent and modulus; a transfer happens when valid and
// ready are high at a rising edge of clk. out_ch carries power_result and
// bad_modulus under the same rule.
// One item is worked on at a time; in_ch.ready is high only while idle.
// The base is first reduced by the modulus, then the exponent is scanned
// from its LSB: a modular multiply for each set bit, a squaring between bits.
// Each modular product runs on a bit-serial shift-and-add engine, one add
// step per cycle.
// The next input transfer can follow in the cycle after the result is registered.
// A zero modulus finishes with result 0 and bad_modulus set; a zero exponent
// gives 1 unreduced.
// The result sits in an output register: a stalled receiver keeps the controller
// in its finish state, the next result held in the datapath, until the previous
// transfer completes, while a new item may already be accepted once the block is idle.
// arst_n clears the controller and drops out_ch.valid; no item is in flight.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_ctrl, mexp_datapath.
module modular_exponentiation import mexp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mexp_in_if.sink   in_ch,
	mexp_out_if.source out_ch
);

	mexp_cmd_t    cmd;
	mexp_status_t status;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mexp_datapath #(
		.W (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.base_in      (in_ch.base_value),
		.expo_in      (in_ch.exponent_value),
		.mod_in       (in_ch.modulus_value),
		.cmd          (cmd),
		.status       (status),
		.power_result (out_ch.power_result),
		.bad_modulus  (out_ch.bad_modulus)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted while an item is in progress");

	a_bad_mod_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.bad_modulus) |-> (out_ch.power_result == '0))
		else $error("bad modulus with nonzero result");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start, cmd.step, cmd.write, cmd.finish}))
		else $error("conflicting datapath commands");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for modular_exponentiation: a directed table, then random items.
// Every result is checked against a typed value or a square-and-multiply predictor in this file.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and modular_exponentiation.
module testbench;
	import mexp_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 76;
	localparam int IDLE_LIMIT = 60000;
	localparam int DIRECTED_COUNT = 24;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef logic [W-1:0] word_t;

	localparam word_t ALL_ONES = '1;
	localparam word_t TOP_BIT = word_t'(1) << (W - 1);
	localparam word_t PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

	typedef struct packed {
		word_t power_result;
		logic  bad_modulus;
	} power_t;

	typedef struct packed {
		word_t base_value;
		word_t exponent_value;
		word_t modulus_value;
		logic  typed;
		word_t want_power;
		logic  want_bad;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n;

	mexp_in_if  in_ch ();
	mexp_out_if out_ch ();

	modular_exponentiation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	power_t expected_powers [$];
	power_t pending_power;
	int     errors = 0;
	int     results_checked = 0;
	int     items_sent = 0;
	int     zero_moduli = 0;
	int     full_exponents = 0;
	int     drains = 0;
	int     sink_hold = 0;
	logic   steady = 1'b0;

	vector_t directed_rows [DIRECTED_COUNT] = '{
		'{64'd5, 64'd3, 64'd0, TYPED, 64'd0, 1'b1},
		'{64'd0, 64'd0, 64'd0, TYPED, 64'd0, 1'b1},
		'{ALL_ONES, ALL_ONES, 64'd0, TYPED, 64'd0, 1'b1},
		'{64'd123, 64'd0, 64'd1, TYPED, 64'd1, 1'b0},
		'{ALL_ONES, 64'd0, ALL_ONES, TYPED, 64'd1, 1'b0},
		'{64'd0, 64'd0, 64'd7, TYPED, 64'd1, 1'b0},
		'{64'd0, 64'd1, 64'd7, TYPED, 64'd0, 1'b0},
		'{64'd0, ALL_ONES, ALL_ONES, TYPED, 64'd0, 1'b0},
		'{64'd1, ALL_ONES, ALL_ONES, TYPED, 64'd1, 1'b0},
		'{64'd2, 64'd10, 64'd1000, TYPED, 64'd24, 1'b0},
		'{64'd3, 64'd1, 64'd1, TYPED, 64'd0, 1'b0},
		'{64'd9, 64'd4, 64'd1, TYPED, 64'd0, 1'b0},
		'{ALL_ONES, 64'd1, ALL_ONES, TYPED, 64'd0, 1'b0},
		'{64'd5, 64'd3, ALL_ONES, TYPED, 64'd125, 1'b0},
		'{64'd7, 64'd5, 64'd7, TYPED, 64'd0, 1'b0},
		'{64'd10, 64'd2, 64'd2, TYPED, 64'd0, 1'b0},
		'{ALL_ONES, 64'd2, TOP_BIT | 64'd1, PREDICTED, 64'd0, 1'b0},
		'{ALL_ONES, ALL_ONES, PRIME_64, PREDICTED, 64'd0, 1'b0},
		'{TOP_BIT, 64'd2, ALL_ONES, PREDICTED, 64'd0, 1'b0},
		'{ALL_ONES, TOP_BIT, TOP_BIT | 64'd1, PREDICTED, 64'd0, 1'b0},
		'{64'd12345, 64'd65537, 64'hFFFF_FFFF_0000_0001, PREDICTED, 64'd0, 1'b0},
		'{64'd3, ALL_ONES, TOP_BIT, PREDICTED, 64'd0, 1'b0},
		'{ALL_ONES - 64'd1, 64'd3, ALL_ONES, PREDICTED, 64'd0, 1'b0},
		'{64'hDEAD_BEEF_CAFE_F00D, 64'd255, PRIME_64, PREDICTED, 64'd0, 1'b0}
	};

	// (x + y) mod m with one carry bit, x and y already below m
	function automatic word_t mod_add(word_t x, word_t y, word_t m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	function automatic word_t mod_product(word_t x, word_t y, word_t m);
		word_t acc;
		word_t dbl;
		word_t rest;
		acc = '0;
		dbl = x % m;
		rest = y;
		while (rest != '0) begin
			if (rest[0])
				acc = mod_add(acc, dbl, m);
			dbl = mod_add(dbl, dbl, m);
			rest = rest >> 1;
		end
		return acc;
	endfunction

	function automatic power_t compute_power(word_t b, word_t e, word_t m);
		power_t r;
		word_t  acc;
		word_t  sq;
		word_t  rest;
		r.power_result = '0;
		r.bad_modulus = 1'b1;
		if (m != '0) begin
			acc = word_t'(1);
			sq = b;
			rest = e;
			while (rest != '0) begin
				if (rest[0])
					acc = mod_product(acc, sq, m);
				sq = mod_product(sq, sq, m);
				rest = rest >> 1;
			end
			r.power_result = acc;
			r.bad_modulus = 1'b0;
		end
		return r;
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 50)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(50, 300);
	endfunction

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		$display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
		errors++;
	endtask

	task automatic send_item(input word_t b, input word_t e, input word_t m,
		input power_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.base_value <= b;
		in_ch.exponent_value <= e;
		in_ch.modulus_value <= m;
		pending_power <= want;
		if (m == '0)
			zero_moduli++;
		if (e[W-1])
			full_exponents++;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_powers.size() != 0)
			@(negedge clk);
		drains++;
	endtask

	task automatic random_item(output word_t b, output word_t e, output word_t m);
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = $urandom_range(0, 12);
		else if (pick < 88)
			len = $urandom_range(13, 24);
		else
			len = W;
		e = rand_word();
		if (len < W)
			e = e & ((word_t'(1) << len) - word_t'(1));
		if (len > 0)
			e[len-1] = 1'b1;

		pick = $urandom_range(0, 99);
		if (pick < 5)
			m = '0;
		else if (pick < 20)
			m = word_t'($urandom_range(1, 255));
		else if (pick < 35)
			m = rand_word() | TOP_BIT;
		else if (pick < 45)
			m = ALL_ONES - word_t'($urandom_range(0, 1000));
		else
			m = rand_word();

		pick = $urandom_range(0, 99);
		if (pick < 10)
			b = word_t'($urandom_range(0, 3));
		else if (pick < 20)
			b = m + word_t'($urandom_range(0, 5));
		else if (pick < 30)
			b = ALL_ONES - word_t'($urandom_range(0, 7));
		else
			b = rand_word();
	endtask

	always @(negedge clk) begin : sink_pacing
		int pick;
		pick = $urandom_range(0, 99);
		if (steady) begin
			out_ch.ready <= 1'b1;
			sink_hold <= 0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else if (pick < 60) begin
			out_ch.ready <= 1'b1;
			sink_hold <= $urandom_range(0, 7);
		end else if (pick < 90) begin
			out_ch.ready <= 1'b0;
			sink_hold <= $urandom_range(0, 3);
		end else if (pick < 97) begin
			out_ch.ready <= 1'b0;
			sink_hold <= $urandom_range(4, 40);
		end else begin
			out_ch.ready <= 1'b0;
			sink_hold <= $urandom_range(100, 400);
		end
	end

	always @(posedge clk) begin : result_check
		power_t want;
		if (out_ch.valid && out_ch.ready) begin
			results_checked++;
			if (expected_powers.size() == 0) begin
				report_mismatch("result with nothing outstanding", out_ch.power_result, '0);
			end else begin
				want = expected_powers.pop_front();
				if (out_ch.power_result !== want.power_result)
					report_mismatch("power_result", out_ch.power_result, want.power_result);
				if (out_ch.bad_modulus !== want.bad_modulus)
					report_mismatch("bad_modulus", word_t'(out_ch.bad_modulus),
						word_t'(want.bad_modulus));
			end
		end
		if (in_ch.valid && in_ch.ready)
			expected_powers.insert(expected_powers.size(), pending_power);
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("FAIL modular_exponentiation");
		$finish;
	end

	initial begin : stimulus
		word_t  b;
		word_t  e;
		word_t  m;
		power_t want;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.base_value = '0;
		in_ch.exponent_value = '0;
		in_ch.modulus_value = '0;
		out_ch.ready = 1'b0;
		pending_power = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed)
				want = '{directed_rows[i].want_power, directed_rows[i].want_bad};
			else
				want = compute_power(directed_rows[i].base_value,
					directed_rows[i].exponent_value, directed_rows[i].modulus_value);
			send_item(directed_rows[i].base_value, directed_rows[i].exponent_value,
				directed_rows[i].modulus_value, want);
		end
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = ((n / 16) % 3) == 2;
			if (n % 25 == 24)
				drain_results();
			random_item(b, e, m);
			send_item(b, e, m, compute_power(b, e, m));
		end
		drain_results();
		repeat (20) @(negedge clk);

		$display("covered %0d items (%0d directed), %0d results checked, %0d errors",
			items_sent, DIRECTED_COUNT, results_checked, errors);
		$display("zero moduli %0d, full-length exponents %0d, sender drains %0d",
			zero_moduli, full_exponents, drains);
		if (errors == 0 && expected_powers.size() == 0)
			$display("PASS modular_exponentiation");
		else
			$display("FAIL modular_exponentiation");
		$finish;
	end

endmodule

FILE: files.f
src/mexp_pkg.sv
src/mexp_in_if.sv
src/mexp_out_if.sv
src/mexp_datapath.sv
src/mexp_ctrl.sv
src/modular_exponentiation.sv
test/testbench.sv
